FILE: sv/substring_or_charset_remover_defines.svh
// Assertion macros shared by the checker of the substring or character-set remover.
// No dependencies; included by the checker file only.
`ifndef SUBSTRING_OR_CHARSET_REMOVER_DEFINES_SVH
`define SUBSTRING_OR_CHARSET_REMOVER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, held off during reset.
`define SOCR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, held off during reset.
`define SOCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/socr_pkg.sv
// Package of the substring or character-set remover: beat types, register
// indexes, controller states and the command and status structs. No dependencies.
`default_nettype none

package socr_pkg;

  // Largest pattern the block holds, and the derived widths.
  localparam int unsigned MAX_PATTERN = 8;
  localparam int unsigned PTR_W       = $clog2(MAX_PATTERN);
  localparam int unsigned CNT_W       = $clog2(MAX_PATTERN + 1);

  // Item kinds.
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SET_MODE       = 2'd0,
    REG_PATTERN_LENGTH = 2'd1,
    REG_PATTERN_BYTES  = 2'd2
  } reg_index_t;

  // One input beat.
  typedef struct packed {
    logic       kind;
    logic [7:0] char_in;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] char_out;
    logic       has_char;
    logic       end_of_string;
    logic       last_in_run;
  } out_item_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_END
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic emit_head;
    logic emit_bare;
    logic eos;
    logic last;
    logic clear;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_is_end;
    logic pass_mode;
    logic out_free;
    logic count_zero;
    logic count_one;
    logic match_cur;
    logic match_full;
    logic last_after_shift;
  } ctrl_sts_t;

endpackage

`default_nettype wire

FILE: sv/substring_or_charset_remover.sv
// Substring or character-set remover: a controller and a datapath that filter a
// character stream, removing pattern occurrences or set members. Depends on socr_pkg.
//
// Character items arrive on the in_ channel and the surviving characters leave on
// the out_ channel through a one-beat result register. The controller steps the
// eight-entry hold buffer one character a cycle while no waiting result beat is
// held off by out_ready. A character item is accepted, then releases its results
// one by one, and closes in a step in which the held characters are found to match
// the pattern prefix or the buffer is empty. An end item is accepted and then sends
// its beats, and the last of those beats closes it. A result beat held off by
// out_ready stalls these steps. A new item is accepted only after the last has closed.
// End items flush the held characters, the last carrying end_of_string, or give one
// bare end beat. Configuration is to be written through cfg_ only while the block is
// idle, which the block itself does not enforce; cfg_ready is always high.
`default_nettype none

module substring_or_charset_remover (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  socr_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output socr_pkg::out_item_t   out_data,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire [1:0]             cfg_index,
  input  wire [63:0]            cfg_data
);

  socr_pkg::ctrl_cmd_t cmd;
  socr_pkg::ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  // Sequencer.
  socr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Buffer, comparators and result register.
  socr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

FILE: sv/socr_ctrl.sv
// Controller of the substring or character-set remover: sequences accept, scan,
// drain and end-of-string flush. Depends on socr_pkg.
`default_nettype none

module socr_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  socr_pkg::ctrl_sts_t   sts,
  output socr_pkg::ctrl_cmd_t   cmd
);

  socr_pkg::state_t state_r;
  socr_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= socr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      socr_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (sts.in_is_end) begin
            state_nxt = socr_pkg::ST_END;
          end else if (sts.pass_mode) begin
            state_nxt = socr_pkg::ST_DRAIN;
          end else begin
            state_nxt = socr_pkg::ST_SCAN;
          end
        end
      end
      socr_pkg::ST_SCAN: begin
        // A held prefix that still matches, or nothing held, ends the scan.
        if (sts.count_zero || sts.match_cur) begin
          state_nxt = socr_pkg::ST_IDLE;
        end
      end
      socr_pkg::ST_DRAIN: begin
        if (sts.count_zero) begin
          state_nxt = socr_pkg::ST_IDLE;
        end
      end
      socr_pkg::ST_END: begin
        // The bare marker or the last held character closes the string.
        if (sts.out_free && (sts.count_zero || sts.count_one)) begin
          state_nxt = socr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = socr_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      socr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      socr_pkg::ST_SCAN: begin
        if (!sts.count_zero) begin
          if (sts.match_cur) begin
            cmd.clear = sts.match_full;
          end else if (sts.out_free) begin
            cmd.emit_head = 1'b1;
            cmd.last      = sts.last_after_shift;
          end
        end
      end
      socr_pkg::ST_DRAIN: begin
        if (!sts.count_zero && sts.out_free) begin
          cmd.emit_head = 1'b1;
          cmd.last      = sts.count_one;
        end
      end
      socr_pkg::ST_END: begin
        if (sts.out_free) begin
          cmd.emit_head = !sts.count_zero;
          cmd.emit_bare = sts.count_zero;
          cmd.eos       = sts.count_zero || sts.count_one;
          cmd.last      = sts.count_zero || sts.count_one;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/socr_dp.sv
// Datapath of the substring or character-set remover: configuration registers,
// held-character buffer, pattern comparators and the result register. Depends on socr_pkg.
`default_nettype none

module socr_dp (
  input  wire                   clk,
  input  wire                   rst_n,
  input  socr_pkg::in_item_t    in_data,
  input  wire                   cfg_valid,
  input  wire [1:0]             cfg_index,
  input  wire [63:0]            cfg_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output socr_pkg::out_item_t   out_data,
  input  socr_pkg::ctrl_cmd_t   cmd,
  output socr_pkg::ctrl_sts_t   sts
);

  localparam int unsigned MP    = socr_pkg::MAX_PATTERN;
  localparam int unsigned CNT_W = socr_pkg::CNT_W;
  localparam int unsigned PTR_W = socr_pkg::PTR_W;

  logic                 set_mode_r;
  logic [3:0]           pattern_length_r;
  logic [63:0]          pattern_bytes_r;
  logic [7:0]           buf_r [MP];
  logic [CNT_W-1:0]     count_r;
  logic                 out_valid_r;
  socr_pkg::out_item_t  out_data_r;

  logic [CNT_W-1:0]     len_eff;
  logic [7:0]           pat [MP];
  logic                 in_set;
  logic                 keep;
  logic                 append;
  logic [MP-1:0]        ok_cur;
  logic [MP-2:0]        ok_sh;

  // Configuration writes; the user must write only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_mode_r       <= 1'b0;
      pattern_length_r <= '0;
      pattern_bytes_r  <= '0;
    end else if (cfg_valid) begin
      case (socr_pkg::reg_index_t'(cfg_index))
        socr_pkg::REG_SET_MODE:       set_mode_r       <= cfg_data[0];
        socr_pkg::REG_PATTERN_LENGTH: pattern_length_r <= cfg_data[3:0];
        socr_pkg::REG_PATTERN_BYTES:  pattern_bytes_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Effective pattern length, clipped to the buffer depth, and the pattern bytes.
  always_comb begin
    if (pattern_length_r > 4'(MP)) begin
      len_eff = CNT_W'(MP);
    end else begin
      len_eff = CNT_W'(pattern_length_r);
    end
    for (int i = 0; i < MP; i++) begin
      pat[i] = pattern_bytes_r[8*i +: 8];
    end
  end

  // Set membership of the incoming character.
  always_comb begin
    in_set = 1'b0;
    for (int i = 0; i < MP; i++) begin
      if (CNT_W'(i) < len_eff && pat[i] == in_data.char_in) begin
        in_set = 1'b1;
      end
    end
  end

  assign keep   = (len_eff == '0) || !in_set;
  assign append = (in_data.kind == socr_pkg::KIND_CHAR) &&
                  (!(set_mode_r || len_eff == '0) || keep);

  // Prefix compare of the held characters, as they stand and shifted by one.
  always_comb begin
    for (int i = 0; i < MP; i++) begin
      ok_cur[i] = (buf_r[i] == pat[i]) || (CNT_W'(i) >= count_r);
    end
    for (int i = 0; i < MP - 1; i++) begin
      ok_sh[i] = (buf_r[i+1] == pat[i]) || (CNT_W'(i + 1) >= count_r);
    end
  end

  // Status towards the controller.
  always_comb begin
    sts.in_is_end        = (in_data.kind == socr_pkg::KIND_END);
    sts.pass_mode        = set_mode_r || (len_eff == '0);
    sts.out_free         = !out_valid_r || out_ready;
    sts.count_zero       = (count_r == '0);
    sts.count_one        = (count_r == CNT_W'(1));
    sts.match_cur        = (&ok_cur) && (count_r <= len_eff);
    sts.match_full       = (count_r == len_eff);
    sts.last_after_shift = (count_r == CNT_W'(1)) ||
                           ((&ok_sh) && (count_r <= len_eff + CNT_W'(1)));
  end

  // Held-character buffer: append at the tail, release from the head.
  always_ff @(posedge clk) begin
    if (cmd.load && append) begin
      buf_r[count_r[PTR_W-1:0]] <= in_data.char_in;
    end else if (cmd.emit_head) begin
      for (int i = 0; i < MP - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
    end
  end

  // Held-character count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.load && append) begin
      count_r <= count_r + CNT_W'(1);
    end else if (cmd.emit_head) begin
      count_r <= count_r - CNT_W'(1);
    end else if (cmd.clear) begin
      count_r <= '0;
    end
  end

  // Result register; a new beat is loaded only when the old one has gone.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_head || cmd.emit_bare) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_head || cmd.emit_bare) begin
      out_data_r.char_out      <= cmd.emit_head ? buf_r[0] : 8'd0;
      out_data_r.has_char      <= cmd.emit_head;
      out_data_r.end_of_string <= cmd.eos;
      out_data_r.last_in_run   <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: sv/socr_checker.sv
// Port-level checker of the substring or character-set remover, bound to the top level.
// Depends on socr_pkg and substring_or_charset_remover_defines.svh.
`default_nettype none

`include "substring_or_charset_remover_defines.svh"

module socr_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input socr_pkg::out_item_t  out_data
);

  // A stalled result beat stays put.
  `SOCR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")

  // The end of a string is always the last beat caused by its item.
  `SOCR_ASSERT_NOW(a_eos_last, clk, rst_n, out_valid && out_data.end_of_string, out_data.last_in_run, "end_of_string without last_in_run")

  // A beat without a character is a bare end marker with a zero byte.
  `SOCR_ASSERT_NOW(a_bare_end, clk, rst_n, out_valid && !out_data.has_char, out_data.end_of_string && out_data.char_out == 8'd0, "bare beat is not a clean end marker")

  // One item at a time: the input closes after each accept.
  `SOCR_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready, "input accepted in back-to-back cycles")

endmodule

bind substring_or_charset_remover socr_checker u_socr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
